[sv/opsv_pkg.sv]
// Shared types and constants of the Ogg page stream validator.
`timescale 1ns / 1ps

package opsv_pkg;

   // Item kinds on the request channel
   localparam logic REQ_PAGE = 1'b0;
   localparam logic REQ_EOF  = 1'b1;

   // Placement constraint codes kept per stream
   localparam logic [1:0] CONS_NONE      = 2'd0;
   localparam logic [1:0] CONS_AFTER_END = 2'd1;
   localparam logic [1:0] CONS_LATE_MUX  = 2'd2;

   // Per-stream flag bits
   typedef struct packed {
      logic f_lost;
      logic f_shown;
      logic f_new;
      logic f_start;
      logic f_end;
   } flags_type;

   // One stream table entry
   typedef struct packed {
      logic [31:0] serial;
      flags_type   flags;
      logic [1:0]  cons;
      logic [31:0] next_seq;
   } entry_type;

   // Request word
   typedef struct packed {
      logic        req_type;
      logic [31:0] page_serial;
      logic        page_bos;
      logic        page_eos;
      logic [31:0] page_seq;
   } req_word_type;

   // Response word
   typedef struct packed {
      logic [4:0]  stream_number;
      logic        new_stream;
      logic        illegal_report;
      logic [1:0]  constraint_code;
      logic        page_skipped;
      logic        missing_bos;
      logic        bos_midstream;
      logic        seq_gap;
      logic [31:0] expected_seq;
      logic        stream_ended;
      logic        table_full;
      logic [4:0]  open_streams;
   } rsp_word_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load;
      logic search;
      logic capture;
      logic commit;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic hit;
      logic scan_end;
      logic is_eof;
      logic out_free;
   } status_type;

endpackage

[sv/opsv_if.sv]
// Valid/ready channel interfaces for request and response words.
`timescale 1ns / 1ps

interface opsv_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [31:0] page_serial;
   logic        page_bos;
   logic        page_eos;
   logic [31:0] page_seq;

   modport source (output valid, output req_type, output page_serial, output page_bos,
                   output page_eos, output page_seq, input ready);
   modport sink (input valid, input req_type, input page_serial, input page_bos,
                 input page_eos, input page_seq, output ready);
endinterface

interface opsv_rsp_if;
   logic        valid;
   logic        ready;
   logic [4:0]  stream_number;
   logic        new_stream;
   logic        illegal_report;
   logic [1:0]  constraint_code;
   logic        page_skipped;
   logic        missing_bos;
   logic        bos_midstream;
   logic        seq_gap;
   logic [31:0] expected_seq;
   logic        stream_ended;
   logic        table_full;
   logic [4:0]  open_streams;

   modport source (output valid, output stream_number, output new_stream,
                   output illegal_report, output constraint_code, output page_skipped,
                   output missing_bos, output bos_midstream, output seq_gap,
                   output expected_seq, output stream_ended, output table_full,
                   output open_streams, input ready);
   modport sink (input valid, input stream_number, input new_stream,
                 input illegal_report, input constraint_code, input page_skipped,
                 input missing_bos, input bos_midstream, input seq_gap,
                 input expected_seq, input stream_ended, input table_full,
                 input open_streams, output ready);
endinterface

[sv/opsv_ram.sv]
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps

module opsv_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/opsv_datapath.sv]
// Datapath: request register, stream table, search pointer, update logic, response register.
`timescale 1ns / 1ps

module opsv_datapath #(
   parameter int MAX_STREAMS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  opsv_pkg::req_word_type req_word,
   input  opsv_pkg::cmd_type     cmd,
   output opsv_pkg::status_type  status,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output opsv_pkg::rsp_word_type rsp_word
);

   localparam int IDX_W = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1;
   localparam int CNT_W = $clog2(MAX_STREAMS + 1);
   localparam int ENT_W = $bits(opsv_pkg::entry_type);

   opsv_pkg::req_word_type req_ff;
   logic [CNT_W-1:0]       ptr_ff, ptr_in;
   logic                   pend_ff, pend_in;
   logic [IDX_W-1:0]       pend_idx_ff;
   logic                   found_ff;
   logic [IDX_W-1:0]       idx_ff;
   opsv_pkg::entry_type    rec_ff;
   logic [CNT_W-1:0]       used_ff, used_in;
   logic [CNT_W-1:0]       open_ff, open_in;
   logic                   header_ff, header_in;
   logic                   rsp_valid_ff;
   opsv_pkg::rsp_word_type rsp_ff, rsp_in;

   logic                   rd_en;
   opsv_pkg::entry_type    rd_data;
   logic                   wr_en;
   opsv_pkg::entry_type    wr_data;
   logic                   hit;
   logic                   full;

   opsv_pkg::flags_type    fl;
   logic [1:0]             cons;
   logic [31:0]            exp_seq;
   logic [CNT_W-1:0]       stream_num;

   // Stream table
   opsv_ram #(
      .WIDTH (ENT_W),
      .DEPTH (MAX_STREAMS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (idx_ff),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (ptr_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   // Scan one entry per cycle, compare the word read in the cycle before
   assign rd_en = cmd.search && (ptr_ff < used_ff);
   assign hit   = pend_ff && (rd_data.serial == req_ff.page_serial);
   assign full  = !found_ff && (used_ff == CNT_W'(MAX_STREAMS));

   always_comb begin
      ptr_in  = ptr_ff;
      pend_in = pend_ff;
      if (cmd.load) begin
         ptr_in  = '0;
         pend_in = 1'b0;
      end else if (cmd.search) begin
         pend_in = rd_en;
         if (rd_en) begin
            ptr_in = ptr_ff + CNT_W'(1);
         end
      end
   end

   assign status.hit      = hit;
   assign status.scan_end = (ptr_ff >= used_ff);
   assign status.is_eof   = (req_word.req_type == opsv_pkg::REQ_EOF);
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   // Work out the response and the new entry for the held request
   always_comb begin
      rsp_in    = '0;
      wr_en     = 1'b0;
      used_in   = used_ff;
      open_in   = open_ff;
      header_in = header_ff;
      fl        = rec_ff.flags;
      cons      = rec_ff.cons;
      exp_seq   = rec_ff.next_seq;
      wr_data   = rec_ff;
      stream_num = CNT_W'(idx_ff) + CNT_W'(1);

      if (req_ff.req_type == opsv_pkg::REQ_EOF) begin
         // Report open streams, then empty the table
         rsp_in.open_streams = 5'(open_ff);
         used_in   = '0;
         open_in   = '0;
         header_in = 1'b0;
      end else if (full) begin
         rsp_in.table_full = 1'b1;
      end else begin
         if (found_ff) begin
            header_in = 1'b0;
            if (rec_ff.flags.f_end) begin
               cons = opsv_pkg::CONS_AFTER_END;
            end else begin
               fl         = '0;
               fl.f_shown = rec_ff.flags.f_shown;
               fl.f_lost  = rec_ff.flags.f_lost;
               fl.f_start = req_ff.page_bos;
               fl.f_end   = req_ff.page_eos;
               if (req_ff.page_eos) begin
                  open_in = open_ff - CNT_W'(1);
               end
            end
            wr_data.serial = rec_ff.serial;
         end else begin
            cons = ((open_ff != '0) && !header_ff) ?
                   opsv_pkg::CONS_LATE_MUX : opsv_pkg::CONS_NONE;
            header_in  = 1'b1;
            used_in    = used_ff + CNT_W'(1);
            exp_seq    = '0;
            fl         = '0;
            fl.f_new   = 1'b1;
            fl.f_start = req_ff.page_bos;
            fl.f_end   = req_ff.page_eos;
            if (!req_ff.page_eos) begin
               open_in = open_ff + CNT_W'(1);
            end
            wr_data.serial = req_ff.page_serial;
         end

         rsp_in.stream_number = 5'(stream_num);
         rsp_in.new_stream    = !found_ff;
         wr_en                = 1'b1;
         wr_data.next_seq     = exp_seq;

         // First illegal placement report, drop the page if not new
         if ((cons != opsv_pkg::CONS_NONE) && !fl.f_shown) begin
            rsp_in.illegal_report  = 1'b1;
            rsp_in.constraint_code = cons;
            fl.f_shown             = 1'b1;
            rsp_in.page_skipped    = !fl.f_new;
         end

         if (!rsp_in.page_skipped) begin
            rsp_in.missing_bos   = fl.f_new && !fl.f_start;
            rsp_in.bos_midstream = !fl.f_new && fl.f_start;
            rsp_in.expected_seq  = exp_seq;
            if (exp_seq != req_ff.page_seq) begin
               rsp_in.seq_gap = !fl.f_lost;
               fl.f_lost      = 1'b1;
            end else begin
               fl.f_lost = 1'b0;
            end
            wr_data.next_seq = req_ff.page_seq + 32'd1;
            if ((cons == opsv_pkg::CONS_NONE) && fl.f_end) begin
               rsp_in.stream_ended = 1'b1;
               cons = opsv_pkg::CONS_AFTER_END;
            end
         end

         wr_data.flags = fl;
         wr_data.cons  = cons;
      end

      wr_en = wr_en && cmd.commit;
   end

   // Hold the request, the search result and the response
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_word;
      end
      if (cmd.search) begin
         pend_idx_ff <= ptr_ff[IDX_W-1:0];
      end
      if (cmd.capture) begin
         found_ff <= hit;
         idx_ff   <= hit ? pend_idx_ff : used_ff[IDX_W-1:0];
         rec_ff   <= rd_data;
      end
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   // Control state: scan pointer and pending flag, table fill, open count, header phase, output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff       <= '0;
         pend_ff      <= 1'b0;
         used_ff      <= '0;
         open_ff      <= '0;
         header_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ptr_ff  <= ptr_in;
         pend_ff <= pend_in;
         if (cmd.commit) begin
            used_ff   <= used_in;
            open_ff   <= open_in;
            header_ff <= header_in;
         end
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule

[sv/opsv_ctrl.sv]
// Controller: sequences accept, table scan and commit of one word at a time.
`timescale 1ns / 1ps

module opsv_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  opsv_pkg::status_type status,
   output opsv_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_SEARCH = 3'b010,
      S_COMMIT = 3'b100
   } state_type;

   state_type state_ff, state_in;

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            // hold off the input while reset is applied
            req_ready = !reset;
            if (req_valid && !reset) begin
               cmd.load = 1'b1;
               state_in = status.is_eof ? S_COMMIT : S_SEARCH;
            end
         end
         S_SEARCH: begin
            cmd.search = 1'b1;
            if (status.hit || status.scan_end) begin
               cmd.capture = 1'b1;
               state_in    = S_COMMIT;
            end
         end
         S_COMMIT: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[sv/ogg_page_stream_validator.sv]
// Top level of the Ogg page stream validator.
`timescale 1ns / 1ps
// Usage:
// req carries one word per page header (serial, begin/end flags, sequence) or an
// end-of-file mark; rsp returns exactly one word for each request word, in order.
// A page scans the stream table one entry per cycle through the table RAM read port,
// so it reads at most N entries, N being the streams in use (at most MAX_STREAMS);
// a hit on an entry ends the scan early. An end-of-file word skips the scan and
// reports the streams still open, then empties the table. One word is in work at a
// time; req is ready again in the cycle after the result is loaded.
// The result sits in an output register: the next request is taken while it waits,
// and a stalled rsp holds it stable; a finished word whose result cannot be loaded
// waits until the register frees up. Reset empties the table at once (fill count
// and open count cleared, no clearing pass), drops any pending result and keeps
// req not ready while it is applied.

module ogg_page_stream_validator #(
   parameter int MAX_STREAMS = 16
) (
   input  logic            clock,
   input  logic            reset,
   opsv_req_if.sink        req,
   opsv_rsp_if.source      rsp
);

   opsv_pkg::req_word_type req_word;
   opsv_pkg::rsp_word_type rsp_word;
   opsv_pkg::cmd_type      cmd;
   opsv_pkg::status_type   status;
   logic                   rsp_valid;

   // Gather the request word
   assign req_word.req_type    = req.req_type;
   assign req_word.page_serial = req.page_serial;
   assign req_word.page_bos    = req.page_bos;
   assign req_word.page_eos    = req.page_eos;
   assign req_word.page_seq    = req.page_seq;

   opsv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .status    (status),
      .cmd       (cmd)
   );

   opsv_datapath #(
      .MAX_STREAMS (MAX_STREAMS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .cmd       (cmd),
      .status    (status),
      .rsp_ready (rsp.ready),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

   // Drive the response channel
   assign rsp.valid           = rsp_valid;
   assign rsp.stream_number   = rsp_word.stream_number;
   assign rsp.new_stream      = rsp_word.new_stream;
   assign rsp.illegal_report  = rsp_word.illegal_report;
   assign rsp.constraint_code = rsp_word.constraint_code;
   assign rsp.page_skipped    = rsp_word.page_skipped;
   assign rsp.missing_bos     = rsp_word.missing_bos;
   assign rsp.bos_midstream   = rsp_word.bos_midstream;
   assign rsp.seq_gap         = rsp_word.seq_gap;
   assign rsp.expected_seq    = rsp_word.expected_seq;
   assign rsp.stream_ended    = rsp_word.stream_ended;
   assign rsp.table_full      = rsp_word.table_full;
   assign rsp.open_streams    = rsp_word.open_streams;

endmodule
